### src/ipv4_header_classifier_stats_core_assert.svh
// Assertion macros for the IPv4 header classifier core.
// Depends on clk and rst_n being visible in the module that includes it.
`ifndef IPV4_HEADER_CLASSIFIER_STATS_CORE_ASSERT_SVH
`define IPV4_HEADER_CLASSIFIER_STATS_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset
`define IHCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included
`define IHCS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IHCS_ASSERT(label, prop, msg)
`define IHCS_ASSERT_RST(label, prop, msg)
`endif

`endif

### src/ihcs_pkg.sv
// Types and constants for the IPv4 header classifier with statistics counters.
// Used by ipv4_header_classifier_stats_core; depends on nothing.
package ihcs_pkg;

  // Item operations
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    FC_IPV4      = 3'd0,
    FC_IPV6      = 3'd1,
    FC_ARP       = 3'd2,
    FC_FLOW_CTRL = 3'd3,
    FC_MACSEC    = 3'd4,
    FC_OTHER     = 3'd5,
    FC_TRUNCATED = 3'd6
  } frame_class_t;

  typedef enum logic [2:0] {
    PC_ICMP   = 3'd0,
    PC_IGMP   = 3'd1,
    PC_IPIP   = 3'd2,
    PC_TCP    = 3'd3,
    PC_UDP    = 3'd4,
    PC_IPV6   = 3'd5,
    PC_OSPF   = 3'd6,
    PC_OTHER  = 3'd7
  } proto_class_t;

  typedef enum logic [2:0] {
    FK_DONT_FRAG = 3'd0,
    FK_FIRST     = 3'd1,
    FK_MIDDLE    = 3'd2,
    FK_LAST      = 3'd3,
    FK_WHOLE     = 3'd4
  } frag_kind_t;

  typedef enum logic [2:0] {
    LB_160   = 3'd0,
    LB_640   = 3'd1,
    LB_1280  = 3'd2,
    LB_5120  = 3'd3,
    LB_ABOVE = 3'd4,
    LB_ZERO  = 3'd5
  } len_bin_t;

  typedef enum logic [2:0] {
    SK_NORMAL      = 3'd0,
    SK_LOW_DELAY   = 3'd1,
    SK_THROUGHPUT  = 3'd2,
    SK_RELIABILITY = 3'd3,
    SK_COST        = 3'd4,
    SK_MIXED       = 3'd5
  } service_kind_t;

  // Ethertypes
  localparam logic [15:0] ET_IPV4   = 16'h0800;
  localparam logic [15:0] ET_IPV6   = 16'h86DD;
  localparam logic [15:0] ET_ARP    = 16'h0806;
  localparam logic [15:0] ET_FLOW   = 16'h8808;
  localparam logic [15:0] ET_MACSEC = 16'h88E5;

  // IP protocol numbers
  localparam logic [7:0] IPP_ICMP = 8'h01;
  localparam logic [7:0] IPP_IGMP = 8'h02;
  localparam logic [7:0] IPP_IPIP = 8'h04;
  localparam logic [7:0] IPP_TCP  = 8'h06;
  localparam logic [7:0] IPP_UDP  = 8'h11;
  localparam logic [7:0] IPP_IPV6 = 8'h29;
  localparam logic [7:0] IPP_OSPF = 8'h59;

  // Byte positions of captured fields
  localparam logic [5:0] POS_ET_HI  = 6'd12;
  localparam logic [5:0] POS_ET_LO  = 6'd13;
  localparam logic [5:0] POS_VIHL   = 6'd14;
  localparam logic [5:0] POS_TOS    = 6'd15;
  localparam logic [5:0] POS_TL_HI  = 6'd16;
  localparam logic [5:0] POS_TL_LO  = 6'd17;
  localparam logic [5:0] POS_FO_HI  = 6'd20;
  localparam logic [5:0] POS_FO_LO  = 6'd21;
  localparam logic [5:0] POS_PROTO  = 6'd23;
  localparam logic [5:0] POS_MAX    = 6'd63;
  // Last position that still makes a truncated frame (frame of 33 bytes)
  localparam logic [5:0] POS_SHORT_MAX = 6'd32;

  // Flag bits of the flags/offset word
  localparam int FLAG_DF_BIT = 14;
  localparam int FLAG_MF_BIT = 13;

  // Service type
  localparam logic [7:0] TOS_MASK        = 8'h1E;
  localparam logic [7:0] TOS_NORMAL      = 8'h00;
  localparam logic [7:0] TOS_LOW_DELAY   = 8'h10;
  localparam logic [7:0] TOS_THROUGHPUT  = 8'h08;
  localparam logic [7:0] TOS_RELIABILITY = 8'h04;
  localparam logic [7:0] TOS_COST        = 8'h02;

  // Length bin upper bounds
  localparam logic [15:0] LEN_BOUND_0 = 16'd159;
  localparam logic [15:0] LEN_BOUND_1 = 16'd639;
  localparam logic [15:0] LEN_BOUND_2 = 16'd1279;
  localparam logic [15:0] LEN_BOUND_3 = 16'd5119;

  // Statistics counters: protocol counters first, then length-bin counters
  localparam int          NUM_CTRS      = 12;
  localparam logic [3:0]  CTR_LEN_BASE  = 4'd7;
  localparam logic [3:0]  CTR_LAST      = 4'd11;
  localparam int          COUNT_WIDTH_DEF = 32;

endpackage

### src/ipv4_header_classifier_stats_core.sv
// IPv4 header classifier core: byte-wise Ethernet/IPv4 header capture, frame report
// and twelve wrapping statistics counters. Uses ihcs_pkg and the assertion header.
// An accepted item passes the input register, then the classify logic and the result register.
// Throughput: one item per cycle; the single classify stage between the two registers
// sets this, and it advances whenever the result register is empty or being taken.
// Reset (rst_n, synchronous, active low): both stages empty, byte position, captured
// header fields and all statistics counters cleared.
`include "ipv4_header_classifier_stats_core_assert.svh"

module ipv4_header_classifier_stats_core #(
  parameter int COUNT_WIDTH = ihcs_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  input  logic [3:0]  in_counter_select,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_frame_class,
  output logic [2:0]  out_proto_class,
  output logic [5:0]  out_header_bytes,
  output logic [15:0] out_payload_len,
  output logic [2:0]  out_fragment_kind,
  output logic [15:0] out_first_data_byte,
  output logic [16:0] out_last_data_byte,
  output logic [2:0]  out_length_bin,
  output logic [2:0]  out_precedence,
  output logic [2:0]  out_service_kind,
  output logic [31:0] out_counter_value
);

  // Input register stage
  logic       s1_valid_r;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic [3:0] s1_sel_r;
  logic       adv;

  // Frame parse state
  logic [5:0]  pos_r;
  logic [5:0]  pos_nxt;
  logic [15:0] ether_type_r;
  logic [7:0]  vihl_r;
  logic [7:0]  tos_r;
  logic [15:0] total_len_r;
  logic [15:0] flags_off_r;
  logic [7:0]  proto_r;

  // Statistics counters
  logic [COUNT_WIDTH-1:0] cnt_r   [ihcs_pkg::NUM_CTRS];
  logic [COUNT_WIDTH-1:0] cnt_nxt [ihcs_pkg::NUM_CTRS];

  // Classification results
  logic [2:0]  frame_class;
  logic [2:0]  proto_class;
  logic [5:0]  hdr_bytes;
  logic [15:0] payload;
  logic [15:0] offset;
  logic [16:0] last_byte;
  logic [2:0]  frag_kind;
  logic [2:0]  len_bin;
  logic [2:0]  svc_kind;
  logic [7:0]  tos_masked;
  logic        is_byte;
  logic        is_read;
  logic        frame_done;
  logic        short_frame;
  logic        ipv4_done;
  logic        has_result;
  logic [31:0] read_value;

  // Result register
  logic        out_valid_r;
  logic [2:0]  frame_class_r;
  logic [2:0]  proto_class_r;
  logic [5:0]  hdr_bytes_r;
  logic [15:0] payload_r;
  logic [2:0]  frag_kind_r;
  logic [15:0] first_byte_r;
  logic [16:0] last_byte_r;
  logic [2:0]  len_bin_r;
  logic [2:0]  prec_r;
  logic [2:0]  svc_kind_r;
  logic [31:0] cnt_value_r;

  // Advance the held item when the result register is free or being taken
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  // Load the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_op_r   <= in_op;
      s1_byte_r <= in_data_byte;
      s1_end_r  <= in_frame_end;
      s1_sel_r  <= in_counter_select;
    end
  end

  assign is_byte     = (s1_op_r == ihcs_pkg::OP_BYTE);
  assign is_read     = (s1_op_r == ihcs_pkg::OP_READ);
  assign frame_done  = is_byte && s1_end_r;
  assign short_frame = (pos_r <= ihcs_pkg::POS_SHORT_MAX);
  assign ipv4_done   = frame_done && !short_frame && (frame_class == ihcs_pkg::FC_IPV4);
  assign has_result  = is_read || frame_done;

  // Advance the byte position: saturate, restart after frame end
  always_comb begin
    pos_nxt = pos_r;
    if (frame_done) begin
      pos_nxt = '0;
    end else if (is_byte && pos_r != ihcs_pkg::POS_MAX) begin
      pos_nxt = pos_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (adv) begin
      pos_r <= pos_nxt;
    end
  end

  // Capture header bytes at their positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ether_type_r <= '0;
      vihl_r       <= '0;
      tos_r        <= '0;
      total_len_r  <= '0;
      flags_off_r  <= '0;
      proto_r      <= '0;
    end else if (adv && is_byte) begin
      case (pos_r)
        ihcs_pkg::POS_ET_HI: ether_type_r[15:8] <= s1_byte_r;
        ihcs_pkg::POS_ET_LO: ether_type_r[7:0]  <= s1_byte_r;
        ihcs_pkg::POS_VIHL:  vihl_r             <= s1_byte_r;
        ihcs_pkg::POS_TOS:   tos_r              <= s1_byte_r;
        ihcs_pkg::POS_TL_HI: total_len_r[15:8]  <= s1_byte_r;
        ihcs_pkg::POS_TL_LO: total_len_r[7:0]   <= s1_byte_r;
        ihcs_pkg::POS_FO_HI: flags_off_r[15:8]  <= s1_byte_r;
        ihcs_pkg::POS_FO_LO: flags_off_r[7:0]   <= s1_byte_r;
        ihcs_pkg::POS_PROTO: proto_r            <= s1_byte_r;
        default: ;
      endcase
    end
  end

  // Classify the ethertype
  always_comb begin
    unique case (ether_type_r)
      ihcs_pkg::ET_IPV4:   frame_class = ihcs_pkg::FC_IPV4;
      ihcs_pkg::ET_IPV6:   frame_class = ihcs_pkg::FC_IPV6;
      ihcs_pkg::ET_ARP:    frame_class = ihcs_pkg::FC_ARP;
      ihcs_pkg::ET_FLOW:   frame_class = ihcs_pkg::FC_FLOW_CTRL;
      ihcs_pkg::ET_MACSEC: frame_class = ihcs_pkg::FC_MACSEC;
      default:             frame_class = ihcs_pkg::FC_OTHER;
    endcase
  end

  // Classify the upper protocol
  always_comb begin
    unique case (proto_r)
      ihcs_pkg::IPP_ICMP: proto_class = ihcs_pkg::PC_ICMP;
      ihcs_pkg::IPP_IGMP: proto_class = ihcs_pkg::PC_IGMP;
      ihcs_pkg::IPP_IPIP: proto_class = ihcs_pkg::PC_IPIP;
      ihcs_pkg::IPP_TCP:  proto_class = ihcs_pkg::PC_TCP;
      ihcs_pkg::IPP_UDP:  proto_class = ihcs_pkg::PC_UDP;
      ihcs_pkg::IPP_IPV6: proto_class = ihcs_pkg::PC_IPV6;
      ihcs_pkg::IPP_OSPF: proto_class = ihcs_pkg::PC_OSPF;
      default:            proto_class = ihcs_pkg::PC_OTHER;
    endcase
  end

  // Header and payload lengths, data byte range
  assign hdr_bytes = {vihl_r[3:0], 2'b00};
  assign payload   = (total_len_r > {10'd0, hdr_bytes}) ?
                     (total_len_r - {10'd0, hdr_bytes}) : 16'd0;
  assign offset    = {flags_off_r[12:0], 3'b000};
  assign last_byte = {1'b0, offset} + {1'b0, payload};

  // Fragment position
  always_comb begin
    priority if (flags_off_r[ihcs_pkg::FLAG_DF_BIT]) begin
      frag_kind = ihcs_pkg::FK_DONT_FRAG;
    end else if (flags_off_r[ihcs_pkg::FLAG_MF_BIT]) begin
      frag_kind = (offset == 16'd0) ? ihcs_pkg::FK_FIRST : ihcs_pkg::FK_MIDDLE;
    end else begin
      frag_kind = (offset == 16'd0) ? ihcs_pkg::FK_WHOLE : ihcs_pkg::FK_LAST;
    end
  end

  // Length bin of the total length
  always_comb begin
    priority if (total_len_r == 16'd0) begin
      len_bin = ihcs_pkg::LB_ZERO;
    end else if (total_len_r <= ihcs_pkg::LEN_BOUND_0) begin
      len_bin = ihcs_pkg::LB_160;
    end else if (total_len_r <= ihcs_pkg::LEN_BOUND_1) begin
      len_bin = ihcs_pkg::LB_640;
    end else if (total_len_r <= ihcs_pkg::LEN_BOUND_2) begin
      len_bin = ihcs_pkg::LB_1280;
    end else if (total_len_r <= ihcs_pkg::LEN_BOUND_3) begin
      len_bin = ihcs_pkg::LB_5120;
    end else begin
      len_bin = ihcs_pkg::LB_ABOVE;
    end
  end

  // Service type
  assign tos_masked = tos_r & ihcs_pkg::TOS_MASK;

  always_comb begin
    unique case (tos_masked)
      ihcs_pkg::TOS_NORMAL:      svc_kind = ihcs_pkg::SK_NORMAL;
      ihcs_pkg::TOS_LOW_DELAY:   svc_kind = ihcs_pkg::SK_LOW_DELAY;
      ihcs_pkg::TOS_THROUGHPUT:  svc_kind = ihcs_pkg::SK_THROUGHPUT;
      ihcs_pkg::TOS_RELIABILITY: svc_kind = ihcs_pkg::SK_RELIABILITY;
      ihcs_pkg::TOS_COST:        svc_kind = ihcs_pkg::SK_COST;
      default:                   svc_kind = ihcs_pkg::SK_MIXED;
    endcase
  end

  // Bump the protocol and length-bin counters of a finished IPv4 frame
  always_comb begin
    for (int i = 0; i < ihcs_pkg::NUM_CTRS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (ipv4_done &&
          ((proto_class != ihcs_pkg::PC_OTHER && {1'b0, proto_class} == 4'(i)) ||
           (len_bin != ihcs_pkg::LB_ZERO &&
            ihcs_pkg::CTR_LEN_BASE + {1'b0, len_bin} == 4'(i)))) begin
        cnt_nxt[i] = cnt_r[i] + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ihcs_pkg::NUM_CTRS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (adv) begin
      for (int i = 0; i < ihcs_pkg::NUM_CTRS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  // Select one counter for a read; unused selects read zero
  assign read_value = (s1_sel_r <= ihcs_pkg::CTR_LAST) ? 32'(cnt_r[s1_sel_r]) : 32'd0;

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= has_result;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: zero everything but the fields that apply
  always_ff @(posedge clk) begin
    if (adv) begin
      frame_class_r <= ihcs_pkg::FC_IPV4;
      proto_class_r <= '0;
      hdr_bytes_r   <= '0;
      payload_r     <= '0;
      frag_kind_r   <= '0;
      first_byte_r  <= '0;
      last_byte_r   <= '0;
      len_bin_r     <= '0;
      prec_r        <= '0;
      svc_kind_r    <= '0;
      cnt_value_r   <= '0;
      if (is_read) begin
        cnt_value_r <= read_value;
      end else if (short_frame) begin
        frame_class_r <= ihcs_pkg::FC_TRUNCATED;
      end else begin
        frame_class_r <= frame_class;
        if (frame_class == ihcs_pkg::FC_IPV4) begin
          proto_class_r <= proto_class;
          hdr_bytes_r   <= hdr_bytes;
          payload_r     <= payload;
          frag_kind_r   <= frag_kind;
          first_byte_r  <= offset;
          last_byte_r   <= last_byte;
          len_bin_r     <= len_bin;
          prec_r        <= tos_r[7:5];
          svc_kind_r    <= svc_kind;
        end
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_class     = frame_class_r;
  assign out_proto_class     = proto_class_r;
  assign out_header_bytes    = hdr_bytes_r;
  assign out_payload_len     = payload_r;
  assign out_fragment_kind   = frag_kind_r;
  assign out_first_data_byte = first_byte_r;
  assign out_last_data_byte  = last_byte_r;
  assign out_length_bin      = len_bin_r;
  assign out_precedence      = prec_r;
  assign out_service_kind    = svc_kind_r;
  assign out_counter_value   = cnt_value_r;

  // Checks
  `IHCS_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid_r, "result valid after reset")
  `IHCS_ASSERT(a_pos_restart, adv && frame_done |=> pos_r == 6'd0, "position not restarted")
  `IHCS_ASSERT(a_read_keeps_pos, adv && is_read |=> pos_r == $past(pos_r), "read moved position")
  `IHCS_ASSERT(a_non_ipv4_zero, out_valid_r && frame_class_r != ihcs_pkg::FC_IPV4 |-> (proto_class_r == 3'd0 && hdr_bytes_r == 6'd0 && payload_r == 16'd0 && cnt_value_r == 32'd0), "non-IPv4 fields set")
  `IHCS_ASSERT(a_range_sum, out_valid_r |-> last_byte_r == {1'b0, first_byte_r} + {1'b0, payload_r}, "data byte range mismatch")

endmodule

### bench/ipv4_header_classifier_stats_core_tb.sv
// Testbench for ipv4_header_classifier_stats_core: frame bytes and counter reads in,
// frame reports and counter values out, checked against an in-bench predictor.
// Depends on ihcs_pkg and the core RTL only.
`timescale 1ns / 100ps

module ipv4_header_classifier_stats_core_tb;
  import ihcs_pkg::*;

  // Counter width for the core under test
  localparam int CNT_W       = 8;
  localparam int CYCLE_LIMIT = 500000;

  typedef logic [7:0] frame_bytes_t [$];

  typedef struct packed {
    frame_class_t  frame_class;
    proto_class_t  proto_class;
    logic [5:0]    header_bytes;
    logic [15:0]   payload_len;
    frag_kind_t    fragment_kind;
    logic [15:0]   first_data_byte;
    logic [16:0]   last_data_byte;
    len_bin_t      length_bin;
    logic [2:0]    precedence;
    service_kind_t service_kind;
    logic [31:0]   counter_value;
  } ip_report_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_BYTE;
  logic [7:0]  in_data_byte = '0;
  logic        in_frame_end = 1'b0;
  logic [3:0]  in_counter_select = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_frame_class;
  logic [2:0]  out_proto_class;
  logic [5:0]  out_header_bytes;
  logic [15:0] out_payload_len;
  logic [2:0]  out_fragment_kind;
  logic [15:0] out_first_data_byte;
  logic [16:0] out_last_data_byte;
  logic [2:0]  out_length_bin;
  logic [2:0]  out_precedence;
  logic [2:0]  out_service_kind;
  logic [31:0] out_counter_value;

  // Captured header state and counters of the predictor
  logic [5:0]       cur_pos   = '0;
  logic [15:0]      cap_etype = '0;
  logic [7:0]       cap_vihl  = '0;
  logic [7:0]       cap_tos   = '0;
  logic [15:0]      cap_tlen  = '0;
  logic [15:0]      cap_fofs  = '0;
  logic [7:0]       cap_proto = '0;
  logic [CNT_W-1:0] stat_count [NUM_CTRS] = '{default: '0};

  ip_report_t report_q [$];
  int errors = 0;
  int items_sent = 0;
  int reports_expected = 0;
  int reports_checked = 0;
  int cycle_cnt = 0;
  int send_gap_pct = 0;
  int stall_pct = 0;

  ipv4_header_classifier_stats_core #(.COUNT_WIDTH(CNT_W)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Work out the report that one accepted item causes, if any
  function automatic bit classify_item(input op_t op, input logic [7:0] b, input logic fe,
                                       input logic [3:0] sel, output ip_report_t r);
    logic short_frame;
    int hdr, payload, offset;
    r = '0;
    if (op == OP_READ) begin
      if (sel <= CTR_LAST) r.counter_value = 32'(stat_count[sel]);
      return 1'b1;
    end
    case (cur_pos)
      POS_ET_HI: cap_etype[15:8] = b;
      POS_ET_LO: cap_etype[7:0] = b;
      POS_VIHL:  cap_vihl = b;
      POS_TOS:   cap_tos = b;
      POS_TL_HI: cap_tlen[15:8] = b;
      POS_TL_LO: cap_tlen[7:0] = b;
      POS_FO_HI: cap_fofs[15:8] = b;
      POS_FO_LO: cap_fofs[7:0] = b;
      POS_PROTO: cap_proto = b;
      default: ;
    endcase
    short_frame = (cur_pos <= POS_SHORT_MAX);
    if (cur_pos != POS_MAX) cur_pos = cur_pos + 6'd1;
    if (!fe) return 1'b0;
    cur_pos = '0;
    if (short_frame) begin
      r.frame_class = FC_TRUNCATED;
      return 1'b1;
    end
    case (cap_etype)
      ET_IPV4:   r.frame_class = FC_IPV4;
      ET_IPV6:   r.frame_class = FC_IPV6;
      ET_ARP:    r.frame_class = FC_ARP;
      ET_FLOW:   r.frame_class = FC_FLOW_CTRL;
      ET_MACSEC: r.frame_class = FC_MACSEC;
      default:   r.frame_class = FC_OTHER;
    endcase
    if (r.frame_class != FC_IPV4) return 1'b1;

    hdr = int'(cap_vihl[3:0]) * 4;
    payload = (int'(cap_tlen) > hdr) ? int'(cap_tlen) - hdr : 0;
    offset = int'(cap_fofs[12:0]) * 8;
    if (cap_fofs[FLAG_DF_BIT]) r.fragment_kind = FK_DONT_FRAG;
    else if (cap_fofs[FLAG_MF_BIT]) r.fragment_kind = (offset == 0) ? FK_FIRST : FK_MIDDLE;
    else r.fragment_kind = (offset == 0) ? FK_WHOLE : FK_LAST;

    case (cap_proto)
      IPP_ICMP: r.proto_class = PC_ICMP;
      IPP_IGMP: r.proto_class = PC_IGMP;
      IPP_IPIP: r.proto_class = PC_IPIP;
      IPP_TCP:  r.proto_class = PC_TCP;
      IPP_UDP:  r.proto_class = PC_UDP;
      IPP_IPV6: r.proto_class = PC_IPV6;
      IPP_OSPF: r.proto_class = PC_OSPF;
      default:  r.proto_class = PC_OTHER;
    endcase

    if (cap_tlen == 16'd0) r.length_bin = LB_ZERO;
    else if (cap_tlen <= LEN_BOUND_0) r.length_bin = LB_160;
    else if (cap_tlen <= LEN_BOUND_1) r.length_bin = LB_640;
    else if (cap_tlen <= LEN_BOUND_2) r.length_bin = LB_1280;
    else if (cap_tlen <= LEN_BOUND_3) r.length_bin = LB_5120;
    else r.length_bin = LB_ABOVE;

    case (cap_tos & TOS_MASK)
      TOS_NORMAL:      r.service_kind = SK_NORMAL;
      TOS_LOW_DELAY:   r.service_kind = SK_LOW_DELAY;
      TOS_THROUGHPUT:  r.service_kind = SK_THROUGHPUT;
      TOS_RELIABILITY: r.service_kind = SK_RELIABILITY;
      TOS_COST:        r.service_kind = SK_COST;
      default:         r.service_kind = SK_MIXED;
    endcase

    r.header_bytes    = 6'(hdr);
    r.payload_len     = 16'(payload);
    r.first_data_byte = 16'(offset);
    r.last_data_byte  = 17'(offset + payload);
    r.precedence      = cap_tos[7:5];

    // Bump the protocol and length-bin counters; they wrap at CNT_W bits
    if (r.proto_class != PC_OTHER) stat_count[r.proto_class] += 1'b1;
    if (r.length_bin != LB_ZERO) stat_count[CTR_LEN_BASE + r.length_bin] += 1'b1;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endfunction

  // Take results, compare with the oldest expectation, drive random stalls
  always @(posedge clk) begin
    ip_report_t want;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("DONE: errors detected");
      $finish;
    end else begin
      cycle_cnt++;
      if (rst_n && out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("result with no item pending");
          errors++;
        end else begin
          want = report_q.pop_front();
          check_field("frame_class", want.frame_class, out_frame_class);
          check_field("proto_class", want.proto_class, out_proto_class);
          check_field("header_bytes", want.header_bytes, out_header_bytes);
          check_field("payload_len", want.payload_len, out_payload_len);
          check_field("fragment_kind", want.fragment_kind, out_fragment_kind);
          check_field("first_data_byte", want.first_data_byte, out_first_data_byte);
          check_field("last_data_byte", want.last_data_byte, out_last_data_byte);
          check_field("length_bin", want.length_bin, out_length_bin);
          check_field("precedence", want.precedence, out_precedence);
          check_field("service_kind", want.service_kind, out_service_kind);
          check_field("counter_value", want.counter_value, out_counter_value);
          reports_checked++;
        end
      end
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Send one item, with random idle cycles ahead of it, and predict its result
  task automatic send_item(input op_t op, input logic [7:0] b, input logic fe,
                           input logic [3:0] sel);
    ip_report_t r;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= op;
    in_data_byte      <= b;
    in_frame_end      <= fe;
    in_counter_select <= sel;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (classify_item(op, b, fe, sel, r)) begin
      report_q.push_back(r);
      reports_expected++;
    end
  endtask

  // Hold the input until every pending result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  function automatic frame_bytes_t build_frame(input logic [15:0] etype,
      input logic [7:0] vihl, input logic [7:0] tos, input logic [15:0] tlen,
      input logic [15:0] fofs, input logic [7:0] proto, input int len);
    frame_bytes_t fr;
    logic [7:0] head [24];
    foreach (head[i]) head[i] = 8'($urandom);
    head[POS_ET_HI] = etype[15:8];
    head[POS_ET_LO] = etype[7:0];
    head[POS_VIHL]  = vihl;
    head[POS_TOS]   = tos;
    head[POS_TL_HI] = tlen[15:8];
    head[POS_TL_LO] = tlen[7:0];
    head[POS_FO_HI] = fofs[15:8];
    head[POS_FO_LO] = fofs[7:0];
    head[POS_PROTO] = proto;
    for (int i = 0; i < len; i++) fr.push_back(i < 24 ? head[i] : 8'($urandom));
    return fr;
  endfunction

  // Send a frame, dropping in counter reads between bytes now and then
  task automatic send_frame(input frame_bytes_t fr, input int read_pct);
    foreach (fr[i]) begin
      if ($urandom_range(99) < read_pct)
        send_item(OP_READ, 8'($urandom), 1'($urandom), 4'($urandom_range(15)));
      send_item(OP_BYTE, fr[i], 1'(i == fr.size() - 1), 4'($urandom));
    end
  endtask

  // Read every select, the unused ones above the last counter included
  task automatic read_all_counters();
    for (int s = 0; s < 16; s++) send_item(OP_READ, 8'($urandom), 1'($urandom), 4'(s));
  endtask

  task automatic test_frame_classes();
    logic [15:0] etypes [5] = '{ET_IPV6, ET_ARP, ET_FLOW, ET_MACSEC, 16'hFFFF};
    // Shortest frame and longest truncated frame
    send_frame(build_frame(ET_IPV4, 8'h45, 8'h00, 16'd60, 16'h0000, IPP_TCP, 1), 0);
    send_frame(build_frame(ET_IPV4, 8'h45, 8'h00, 16'd60, 16'h0000, IPP_TCP, 33), 0);
    // Shortest full frames of every other ethertype class
    foreach (etypes[k])
      send_frame(build_frame(etypes[k], 8'h45, 8'h00, 16'd60, 16'h0000, IPP_TCP, 34), 0);
  endtask

  // IPv4 frames over fragment kinds, length bins, service kinds and length clamping;
  // the second frame carries a version nibble other than four
  task automatic test_header_fields();
    logic [7:0]  vihls  [5] = '{8'h45, 8'h6F, 8'h40, 8'h4F, 8'h47};
    logic [7:0]  toss   [5] = '{8'h10, 8'hE8, 8'h24, 8'h02, 8'h00};
    logic [15:0] tlens  [5] = '{16'd0, 16'd160, 16'd640, 16'd5119, 16'd20};
    logic [15:0] fofss  [5] = '{16'h4000, 16'h2000, 16'h2001, 16'h1FFF, 16'h0000};
    logic [7:0]  protos [5] = '{IPP_ICMP, IPP_IGMP, IPP_IPIP, IPP_OSPF, IPP_TCP};
    for (int k = 0; k < 5; k++) begin
      send_frame(build_frame(ET_IPV4, vihls[k], toss[k], tlens[k], fofss[k], protos[k], 34),
                 0);
      send_item(OP_READ, 8'($urandom), 1'($urandom), 4'(k));
    end
  endtask

  // Frame past the position saturation point, with reads inside it
  task automatic test_long_frame();
    send_frame(build_frame(ET_IPV4, 8'h46, 8'h3F, 16'hFFFF, 16'h9FFF, 8'hFF, 66), 10);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles often, receiver stalls more
    send_gap_pct = 35;
    stall_pct = 76;
    test_frame_classes();
    wait_for_results();

    // The other way round
    send_gap_pct = 76;
    stall_pct = 35;
    test_header_fields();
    wait_for_results();

    // Back to back on both sides
    send_gap_pct = 0;
    stall_pct = 0;
    test_long_frame();
    read_all_counters();

    // Drain, then watch a few more cycles for stray results
    wait_for_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d items, expected %0d and checked %0d results: frame classes,",
             items_sent, reports_expected, reports_checked);
    $display("truncation, header fields, a saturating long frame and counter reads.");
    if (errors == 0 && report_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
